FILE: design/rccd_pkg.sv
// shared types and constants for the roi colour class detector
// pixel and result request formats, register indexes, colour box limits
// no dependencies
package rccd_pkg;

  localparam int NumClasses = 6;

  // class positions within the counter and limit arrays
  localparam int ClsRed    = 0;
  localparam int ClsOrange = 1;
  localparam int ClsWhite  = 2;
  localparam int ClsGreen  = 3;
  localparam int ClsBanana = 4;
  localparam int ClsKiwi   = 5;

  localparam int CfgIndexW = 4;
  localparam int CfgDataW  = 12;
  localparam int LimitW    = 12;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] REG_WINDOW_LEFT  = 4'd0;
  localparam logic [CfgIndexW-1:0] REG_WINDOW_TOP   = 4'd1;
  localparam logic [CfgIndexW-1:0] REG_RED_LIMIT    = 4'd2;
  localparam logic [CfgIndexW-1:0] REG_ORANGE_LIMIT = 4'd3;
  localparam logic [CfgIndexW-1:0] REG_WHITE_LIMIT  = 4'd4;
  localparam logic [CfgIndexW-1:0] REG_GREEN_LIMIT  = 4'd5;
  localparam logic [CfgIndexW-1:0] REG_BANANA_LIMIT = 4'd6;
  localparam logic [CfgIndexW-1:0] REG_KIWI_LIMIT   = 4'd7;

  localparam logic [8:0] WINDOW_LEFT_RESET = 9'd150;
  localparam logic [7:0] WINDOW_TOP_RESET  = 8'd110;
  localparam logic [LimitW-1:0] LIMIT_RESET [NumClasses] =
    '{12'd400, 12'd400, 12'd3000, 12'd250, 12'd250, 12'd400};

  // colour box bounds, all compared strictly
  localparam logic [7:0] RED_B_MAX    = 8'd120;
  localparam logic [7:0] RED_G_MAX    = 8'd70;
  localparam logic [7:0] RED_R_MIN    = 8'd210;
  localparam logic [7:0] ORANGE_B_MAX = 8'd80;
  localparam logic [7:0] ORANGE_G_MIN = 8'd100;
  localparam logic [7:0] ORANGE_R_MIN = 8'd160;
  localparam logic [7:0] WHITE_MIN    = 8'd235;
  localparam logic [7:0] GREEN_B_MAX  = 8'd70;
  localparam logic [7:0] GREEN_G_MIN  = 8'd80;
  localparam logic [7:0] GREEN_R_MAX  = 8'd70;
  localparam logic [7:0] BANANA_B_MIN = 8'd45;
  localparam logic [7:0] BANANA_B_MAX = 8'd90;
  localparam logic [7:0] BANANA_G_MIN = 8'd75;
  localparam logic [7:0] BANANA_G_MAX = 8'd115;
  localparam logic [7:0] BANANA_R_MIN = 8'd100;
  localparam logic [7:0] BANANA_R_MAX = 8'd150;
  localparam logic [7:0] KIWI_B_MAX   = 8'd110;
  localparam logic [7:0] KIWI_G_MIN   = 8'd150;
  localparam logic [7:0] KIWI_R_MIN   = 8'd150;
  localparam logic [7:0] KIWI_R_MAX   = 8'd200;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [8:0] col;
    logic [7:0] row;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    logic [2:0] detected_class;
    logic [5:0] triggered_mask;
  } result_t;

  // one bit per colour box that contains the pixel
  function automatic logic [NumClasses-1:0] box_hits(input logic [7:0] b,
                                                      input logic [7:0] g,
                                                      input logic [7:0] r);
    logic [NumClasses-1:0] m;
    m = '0;
    m[ClsRed]    = (b < RED_B_MAX) && (g < RED_G_MAX) && (r > RED_R_MIN);
    m[ClsOrange] = (b < ORANGE_B_MAX) && (g > ORANGE_G_MIN) && (r > ORANGE_R_MIN);
    m[ClsWhite]  = (b > WHITE_MIN) && (g > WHITE_MIN) && (r > WHITE_MIN);
    m[ClsGreen]  = (b < GREEN_B_MAX) && (g > GREEN_G_MIN) && (r < GREEN_R_MAX);
    m[ClsBanana] = (b > BANANA_B_MIN) && (b < BANANA_B_MAX) &&
                   (g > BANANA_G_MIN) && (g < BANANA_G_MAX) &&
                   (r > BANANA_R_MIN) && (r < BANANA_R_MAX);
    m[ClsKiwi]   = (b < KIWI_B_MAX) && (g > KIWI_G_MIN) &&
                   (r > KIWI_R_MIN) && (r < KIWI_R_MAX);
    return m;
  endfunction

endpackage

FILE: design/roi_color_class_detector_top.sv
// top level of the roi colour class detector
// pixel register, colour box test, class counters and result register
// depends on rccd_pkg
//
// usage:
//   pixel channel: one pixel request (colour, column, row, frame_end) per
//   cycle on pixel_valid / pixel_stall; taken when valid is high and stall low
//   result channel: one result request per frame, issued for the pixel that
//   carries frame_end, on result_valid / result_stall
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high; the user must write only while the block is idle
//   and the block does not enforce it; results pass both pipeline registers
//   throughput: one pixel per cycle; the only stall comes from a frame_end
//   pixel waiting in the pixel register while the result register is full
//   and its receiver stalls
//   reset: synchronous, active high; counters clear to zero, window and
//   limits take their reset values, both pipeline registers empty
//   when the receiver stalls the result is held; ordinary pixels keep
//   flowing and only the next frame_end pixel waits
module roi_color_class_detector_top #(
  parameter int WINDOW_SIZE = 20,
  parameter int COUNT_BITS  = 13
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_stall,
  input  rccd_pkg::pixel_t                   pixel,
  output logic                               result_valid,
  input  logic                               result_stall,
  output rccd_pkg::result_t                  result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rccd_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [rccd_pkg::CfgDataW-1:0]      cfg_data
);

  // widths of the window end bounds, wide enough that they never wrap
  localparam int ColEndW = $clog2(512 + WINDOW_SIZE);
  localparam int RowEndW = $clog2(256 + WINDOW_SIZE);
  // compare width for count against limit
  localparam int CmpW = (COUNT_BITS > rccd_pkg::LimitW) ? COUNT_BITS : rccd_pkg::LimitW;

  // configuration
  logic [8:0]                  window_left;
  logic [7:0]                  window_top;
  logic [rccd_pkg::LimitW-1:0] limits [rccd_pkg::NumClasses];

  // class counters
  logic [COUNT_BITS-1:0]       counts      [rccd_pkg::NumClasses];
  logic [COUNT_BITS-1:0]       counts_next [rccd_pkg::NumClasses];

  // pixel register
  logic                        pix_valid;
  rccd_pkg::pixel_t            pix;

  // combinational results for the registered pixel
  logic                        in_window;
  logic [rccd_pkg::NumClasses-1:0] hits;
  logic [rccd_pkg::NumClasses-1:0] trig_mask;
  logic [2:0]                  trig_class;
  logic                        pix_advance;
  logic                        pix_fire;
  logic                        emit;
  logic [ColEndW-1:0]          col_end;
  logic [RowEndW-1:0]          row_end;

  assign cfg_ready = 1'b1;

  // config writes, index beyond the list ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      window_left <= rccd_pkg::WINDOW_LEFT_RESET;
      window_top  <= rccd_pkg::WINDOW_TOP_RESET;
      for (int k = 0; k < rccd_pkg::NumClasses; k++) begin
        limits[k] <= rccd_pkg::LIMIT_RESET[k];
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rccd_pkg::REG_WINDOW_LEFT:  window_left <= cfg_data[8:0];
        rccd_pkg::REG_WINDOW_TOP:   window_top  <= cfg_data[7:0];
        rccd_pkg::REG_RED_LIMIT:    limits[rccd_pkg::ClsRed]    <= cfg_data;
        rccd_pkg::REG_ORANGE_LIMIT: limits[rccd_pkg::ClsOrange] <= cfg_data;
        rccd_pkg::REG_WHITE_LIMIT:  limits[rccd_pkg::ClsWhite]  <= cfg_data;
        rccd_pkg::REG_GREEN_LIMIT:  limits[rccd_pkg::ClsGreen]  <= cfg_data;
        rccd_pkg::REG_BANANA_LIMIT: limits[rccd_pkg::ClsBanana] <= cfg_data;
        rccd_pkg::REG_KIWI_LIMIT:   limits[rccd_pkg::ClsKiwi]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // a frame_end pixel may only leave once the result register has room
  assign pix_advance = !(pix.frame_end && result_valid && result_stall);
  assign pix_fire    = pix_valid && pix_advance;
  assign emit        = pix_fire && pix.frame_end;
  assign pixel_stall = pix_valid && !pix_advance;

  // pixel register, refilled whenever its content moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!pixel_stall) begin
      pix_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!pixel_stall && pixel_valid) begin
      pix <= pixel;
    end
  end

  // window test, bounds widened so they never wrap
  assign col_end   = ColEndW'(window_left) + ColEndW'(WINDOW_SIZE);
  assign row_end   = RowEndW'(window_top) + RowEndW'(WINDOW_SIZE);
  assign in_window = (pix.col >= window_left) && (ColEndW'(pix.col) < col_end) &&
                     (pix.row >= window_top) && (RowEndW'(pix.row) < row_end);
  assign hits      = rccd_pkg::box_hits(pix.blue, pix.green, pix.red);

  // saturating count, then threshold test on the updated value
  always_comb begin
    trig_class = '0;
    trig_mask  = '0;
    for (int k = 0; k < rccd_pkg::NumClasses; k++) begin
      counts_next[k] = counts[k];
      if (in_window && hits[k] && (counts[k] != {COUNT_BITS{1'b1}})) begin
        counts_next[k] = counts[k] + 1'b1;
      end
      if (pix.frame_end && (CmpW'(counts_next[k]) > CmpW'(limits[k]))) begin
        trig_mask[k]   = 1'b1;
        trig_class     = 3'(k + 1);
        counts_next[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < rccd_pkg::NumClasses; k++) begin
        counts[k] <= '0;
      end
    end else if (pix_fire) begin
      counts <= counts_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.detected_class <= trig_class;
      result.triggered_mask <= trig_mask;
    end
  end

  // stall only ever comes from a frame_end pixel blocked by a held result
  assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (pix_valid && pix.frame_end && result_valid && result_stall))
    else $error("pixel stall without a blocked frame end");

  // a class is reported exactly when some class triggered
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.detected_class == 3'd0) == (result.triggered_mask == 6'd0)))
    else $error("detected class disagrees with trigger mask");

  // an ordinary pixel never creates a result
  assert property (@(posedge clk) disable iff (rst)
    (pix_fire && !pix.frame_end) |=> (result_valid == $past(result_valid && result_stall)))
    else $error("result raised without a frame end");

  // a triggered red class starts the next frame from zero
  assert property (@(posedge clk) disable iff (rst)
    (emit && trig_mask[rccd_pkg::ClsRed]) |=> (counts[rccd_pkg::ClsRed] == '0))
    else $error("red counter not cleared after trigger");

endmodule

FILE: bench/testbench.sv
// testbench for the roi colour class detector top level
// sends pixel requests and register writes, predicts every frame result and checks it
// depends on rccd_pkg and roi_color_class_detector_top
module testbench;

  localparam int WindowSize = 20;
  localparam int CountBits  = 13;
  localparam logic [CountBits-1:0] CountMax = '1;
  // first register index past the end of the register list
  localparam int NumRegs = 8;
  // extra wait once every owed result has arrived, as margin
  localparam int DrainCycles = 4;
  // white pixels per frame in the carry test, below the limit alone, above it over two frames
  localparam int CarryPixels = 60;
  localparam logic [rccd_pkg::CfgDataW-1:0] CarryLimit = 12'd100;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              pixel_valid = 1'b0;
  logic              pixel_stall;
  rccd_pkg::pixel_t  pixel = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  rccd_pkg::result_t result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [rccd_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [rccd_pkg::CfgDataW-1:0]  cfg_data  = '0;

  // predicted block state: window, limits and running class counts
  logic [8:0]                  window_left_q;
  logic [7:0]                  window_top_q;
  logic [rccd_pkg::LimitW-1:0] class_limit [rccd_pkg::NumClasses];
  logic [CountBits-1:0]        class_count [rccd_pkg::NumClasses];

  // frame results still owed by the block, oldest first
  rccd_pkg::result_t frame_results [$];

  int mismatches  = 0;
  int pixels_sent = 0;
  // random idling on both sides while set
  bit gaps_on     = 1'b1;
  int stall_left  = 0;

  roi_color_class_detector_top #(
    .WINDOW_SIZE (WindowSize),
    .COUNT_BITS  (CountBits)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // register values and counts right after reset
  task automatic load_reset_state;
    window_left_q = 9'd150;
    window_top_q  = 8'd110;
    class_limit   = '{12'd400, 12'd400, 12'd3000, 12'd250, 12'd250, 12'd400};
    foreach (class_count[k]) class_count[k] = '0;
  endtask

  // strictly between two bounds
  function automatic bit between(int v, int lo, int hi);
    return v > lo && v < hi;
  endfunction

  // which colour boxes hold the pixel, one bit per class
  function automatic logic [rccd_pkg::NumClasses-1:0] colour_boxes(int b, int g, int r);
    logic [rccd_pkg::NumClasses-1:0] hit;
    hit[rccd_pkg::ClsRed]    = between(b, -1, rccd_pkg::RED_B_MAX) &&
                               between(g, -1, rccd_pkg::RED_G_MAX) &&
                               between(r, rccd_pkg::RED_R_MIN, 256);
    hit[rccd_pkg::ClsOrange] = between(b, -1, rccd_pkg::ORANGE_B_MAX) &&
                               between(g, rccd_pkg::ORANGE_G_MIN, 256) &&
                               between(r, rccd_pkg::ORANGE_R_MIN, 256);
    hit[rccd_pkg::ClsWhite]  = between(b, rccd_pkg::WHITE_MIN, 256) &&
                               between(g, rccd_pkg::WHITE_MIN, 256) &&
                               between(r, rccd_pkg::WHITE_MIN, 256);
    hit[rccd_pkg::ClsGreen]  = between(b, -1, rccd_pkg::GREEN_B_MAX) &&
                               between(g, rccd_pkg::GREEN_G_MIN, 256) &&
                               between(r, -1, rccd_pkg::GREEN_R_MAX);
    hit[rccd_pkg::ClsBanana] = between(b, rccd_pkg::BANANA_B_MIN, rccd_pkg::BANANA_B_MAX) &&
                               between(g, rccd_pkg::BANANA_G_MIN, rccd_pkg::BANANA_G_MAX) &&
                               between(r, rccd_pkg::BANANA_R_MIN, rccd_pkg::BANANA_R_MAX);
    hit[rccd_pkg::ClsKiwi]   = between(b, -1, rccd_pkg::KIWI_B_MAX) &&
                               between(g, rccd_pkg::KIWI_G_MIN, 256) &&
                               between(r, rccd_pkg::KIWI_R_MIN, rccd_pkg::KIWI_R_MAX);
    return hit;
  endfunction

  // window bounds taken without wrap, so a window past the frame edge just shrinks
  function automatic bit in_window(logic [8:0] c, logic [7:0] r);
    int left;
    int top;
    left = window_left_q;
    top  = window_top_q;
    return int'(c) >= left && int'(c) < left + WindowSize &&
           int'(r) >= top && int'(r) < top + WindowSize;
  endfunction

  // count one accepted pixel; on frame_end settle the frame and owe a result
  task automatic tally_pixel(input rccd_pkg::pixel_t p);
    logic [rccd_pkg::NumClasses-1:0] hit;
    rccd_pkg::result_t               res;
    hit = colour_boxes(p.blue, p.green, p.red);
    if (in_window(p.col, p.row)) begin
      for (int k = 0; k < rccd_pkg::NumClasses; k++) begin
        // counts stick at the top rather than wrap
        if (hit[k] && class_count[k] != CountMax) class_count[k] = class_count[k] + 1'b1;
      end
    end
    if (p.frame_end) begin
      res = '0;
      for (int k = 0; k < rccd_pkg::NumClasses; k++) begin
        if (class_count[k] > class_limit[k]) begin
          res.triggered_mask[k] = 1'b1;
          // later classes overwrite, so the highest one wins
          res.detected_class = 3'(k + 1);
          class_count[k] = '0;
        end
      end
      frame_results.push_back(res);
    end
  endtask

  // register write as the block sees it; indexes past the list are dropped
  task automatic apply_reg(input logic [rccd_pkg::CfgIndexW-1:0] idx,
                           input logic [rccd_pkg::CfgDataW-1:0] data);
    if (idx == rccd_pkg::REG_WINDOW_LEFT) begin
      window_left_q = data[8:0];
    end else if (idx == rccd_pkg::REG_WINDOW_TOP) begin
      window_top_q = data[7:0];
    end else if (idx >= rccd_pkg::REG_RED_LIMIT && idx <= rccd_pkg::REG_KIWI_LIMIT) begin
      class_limit[idx - rccd_pkg::REG_RED_LIMIT] = data[rccd_pkg::LimitW-1:0];
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic rccd_pkg::pixel_t pixel_at(int b, int g, int r, int c, int rw, bit last);
    rccd_pkg::pixel_t p;
    p.blue      = 8'(b);
    p.green     = 8'(g);
    p.red       = 8'(r);
    p.col       = 9'(c);
    p.row       = 8'(rw);
    p.frame_end = last;
    return p;
  endfunction

  // random colour strictly inside one class's box, {blue, green, red}
  function automatic logic [23:0] colour_in_box(int cls);
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    case (cls)
      rccd_pkg::ClsRed: begin
        b = 8'($urandom_range(rccd_pkg::RED_B_MAX - 1, 0));
        g = 8'($urandom_range(rccd_pkg::RED_G_MAX - 1, 0));
        r = 8'($urandom_range(255, rccd_pkg::RED_R_MIN + 1));
      end
      rccd_pkg::ClsOrange: begin
        b = 8'($urandom_range(rccd_pkg::ORANGE_B_MAX - 1, 0));
        g = 8'($urandom_range(255, rccd_pkg::ORANGE_G_MIN + 1));
        r = 8'($urandom_range(255, rccd_pkg::ORANGE_R_MIN + 1));
      end
      rccd_pkg::ClsWhite: begin
        b = 8'($urandom_range(255, rccd_pkg::WHITE_MIN + 1));
        g = 8'($urandom_range(255, rccd_pkg::WHITE_MIN + 1));
        r = 8'($urandom_range(255, rccd_pkg::WHITE_MIN + 1));
      end
      rccd_pkg::ClsGreen: begin
        b = 8'($urandom_range(rccd_pkg::GREEN_B_MAX - 1, 0));
        g = 8'($urandom_range(255, rccd_pkg::GREEN_G_MIN + 1));
        r = 8'($urandom_range(rccd_pkg::GREEN_R_MAX - 1, 0));
      end
      rccd_pkg::ClsBanana: begin
        b = 8'($urandom_range(rccd_pkg::BANANA_B_MAX - 1, rccd_pkg::BANANA_B_MIN + 1));
        g = 8'($urandom_range(rccd_pkg::BANANA_G_MAX - 1, rccd_pkg::BANANA_G_MIN + 1));
        r = 8'($urandom_range(rccd_pkg::BANANA_R_MAX - 1, rccd_pkg::BANANA_R_MIN + 1));
      end
      rccd_pkg::ClsKiwi: begin
        b = 8'($urandom_range(rccd_pkg::KIWI_B_MAX - 1, 0));
        g = 8'($urandom_range(255, rccd_pkg::KIWI_G_MIN + 1));
        r = 8'($urandom_range(rccd_pkg::KIWI_R_MAX - 1, rccd_pkg::KIWI_R_MIN + 1));
      end
      default: begin
        b = 8'($urandom);
        g = 8'($urandom);
        r = 8'($urandom);
      end
    endcase
    return {b, g, r};
  endfunction

  // mostly in-window pixels, the rest anywhere; colours mostly aimed at a box
  function automatic rccd_pkg::pixel_t random_pixel(bit last);
    rccd_pkg::pixel_t p;
    p.frame_end = last;
    if ($urandom_range(99) < 75) begin
      p.col = 9'(window_left_q + $urandom_range(WindowSize - 1));
      p.row = 8'(window_top_q + $urandom_range(WindowSize - 1));
    end else begin
      p.col = 9'($urandom_range(511));
      p.row = 8'($urandom_range(255));
    end
    // a draw of NumClasses means a fully random colour
    {p.blue, p.green, p.red} = colour_in_box($urandom_range(rccd_pkg::NumClasses));
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // request drivers: inputs change on the falling edge, handshakes seen on the rising
  // ---------------------------------------------------------------------------

  // one pixel request; valid stays high afterwards so back-to-back requests flow
  task automatic send_pixel(input rccd_pkg::pixel_t p);
    int gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(9) == 0) begin
      gap = $urandom_range(14, 1);
      pixel_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid = 1'b1;
    pixel       = p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    tally_pixel(p);
    pixels_sent++;
  endtask

  task automatic write_reg(input logic [rccd_pkg::CfgIndexW-1:0] idx,
                           input logic [rccd_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop sending, let every owed result arrive, then give the pipeline time to empty
  task automatic wait_idle;
    int guard;
    guard = 0;
    @(negedge clk);
    pixel_valid = 1'b0;
    while (frame_results.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    if (frame_results.size() != 0) begin
      $error("frame results never arrived: %0d outstanding", frame_results.size());
      mismatches++;
      frame_results.delete();
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  // receiver side: stall in bursts of random length
  always @(negedge clk) begin : result_stall_gen
    if (stall_left > 0) begin
      result_stall = 1'b1;
      stall_left--;
    end else if (gaps_on && $urandom_range(5) == 0) begin
      result_stall = 1'b1;
      stall_left   = $urandom_range(13);
    end else begin
      result_stall = 1'b0;
    end
  end

  // compare each accepted result request with the oldest owed frame result
  always @(posedge clk) begin : check_results
    rccd_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (frame_results.size() == 0) begin
        $error("unexpected result: detected_class %0d triggered_mask %b",
               result.detected_class, result.triggered_mask);
        mismatches++;
      end else begin
        want = frame_results.pop_front();
        if (result.detected_class !== want.detected_class) begin
          $error("detected_class: expected %0d, actual %0d",
                 want.detected_class, result.detected_class);
          mismatches++;
        end
        if (result.triggered_mask !== want.triggered_mask) begin
          $error("triggered_mask: expected %b, actual %b",
                 want.triggered_mask, result.triggered_mask);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // window at its reset place (150..169, 110..129), limits too high to trigger
  task automatic test_reset_values;
    send_pixel(pixel_at(255, 255, 255, 150, 110, 0));
    send_pixel(pixel_at(255, 255, 255, 169, 129, 0));
    // one past the right and bottom edges, and one before the left edge
    send_pixel(pixel_at(255, 255, 255, 170, 110, 0));
    send_pixel(pixel_at(255, 255, 255, 150, 130, 0));
    send_pixel(pixel_at(255, 255, 255, 149, 129, 0));
    // frame with nothing over its limit still gives an all-zero result
    send_pixel(pixel_at(0, 0, 0, 0, 0, 1));
  endtask

  // limits at zero so one hit triggers; colours just inside and just outside some box edges
  task automatic test_box_edges;
    wait_idle();
    for (int k = 0; k < rccd_pkg::NumClasses; k++)
      write_reg(rccd_pkg::CfgIndexW'(rccd_pkg::REG_RED_LIMIT + k), '0);
    send_pixel(pixel_at(119, 69, 211, 160, 120, 0));
    send_pixel(pixel_at(120, 69, 211, 160, 120, 0));
    send_pixel(pixel_at(79, 101, 161, 160, 120, 0));
    send_pixel(pixel_at(235, 255, 255, 160, 120, 0));
    send_pixel(pixel_at(69, 81, 69, 160, 120, 0));
    send_pixel(pixel_at(46, 76, 101, 160, 120, 0));
    send_pixel(pixel_at(89, 114, 149, 160, 120, 0));
    send_pixel(pixel_at(45, 100, 120, 160, 120, 0));
    // inside both the orange and the kiwi box
    send_pixel(pixel_at(0, 255, 180, 160, 120, 0));
    // frame_end pixel counts before the frame is settled; every class fires
    send_pixel(pixel_at(255, 255, 255, 160, 120, 1));
    send_pixel(pixel_at(0, 0, 0, 511, 255, 1));
  endtask

  // window at both extremes; upper data bits must be dropped by the registers
  task automatic test_window_edges;
    wait_idle();
    write_reg(rccd_pkg::REG_WINDOW_LEFT, '1);
    write_reg(rccd_pkg::REG_WINDOW_TOP, '1);
    send_pixel(pixel_at(100, 0, 255, 511, 255, 0));
    send_pixel(pixel_at(0, 0, 0, 510, 255, 1));
    wait_idle();
    write_reg(rccd_pkg::REG_WINDOW_LEFT, '0);
    write_reg(rccd_pkg::REG_WINDOW_TOP, '0);
    send_pixel(pixel_at(0, 255, 0, 0, 0, 0));
    send_pixel(pixel_at(0, 255, 0, 19, 19, 1));
    send_pixel(pixel_at(0, 255, 0, 20, 0, 0));
    send_pixel(pixel_at(0, 255, 0, 0, 20, 1));
  endtask

  // a count below its limit carries into the next frame, and restarts from zero once it fires
  task automatic test_count_carry;
    wait_idle();
    for (int k = 0; k < rccd_pkg::NumClasses; k++)
      write_reg(rccd_pkg::CfgIndexW'(rccd_pkg::REG_RED_LIMIT + k), '1);
    write_reg(rccd_pkg::REG_WHITE_LIMIT, CarryLimit);
    for (int f = 0; f < 2; f++) begin
      for (int i = 0; i < CarryPixels; i++)
        send_pixel(pixel_at(255, 255, 255, i % WindowSize, i / WindowSize, 0));
      send_pixel(pixel_at(0, 0, 0, 300, 200, 1));
    end
    send_pixel(pixel_at(255, 255, 255, 5, 5, 0));
    send_pixel(pixel_at(0, 0, 0, 300, 200, 1));
  endtask

  // random frames over several register settings, extremes first
  task automatic test_random_frames;
    int len;
    int target;
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      // no idling in the closing phases
      gaps_on = phase < 6;
      case (phase)
        0: begin
          write_reg(rccd_pkg::REG_WINDOW_LEFT, '0);
          write_reg(rccd_pkg::REG_WINDOW_TOP, '0);
          for (int k = 0; k < rccd_pkg::NumClasses; k++)
            write_reg(rccd_pkg::CfgIndexW'(rccd_pkg::REG_RED_LIMIT + k), '0);
        end
        1: begin
          write_reg(rccd_pkg::REG_WINDOW_LEFT, '1);
          write_reg(rccd_pkg::REG_WINDOW_TOP, '1);
          for (int k = 0; k < rccd_pkg::NumClasses; k++)
            write_reg(rccd_pkg::CfgIndexW'(rccd_pkg::REG_RED_LIMIT + k), '1);
        end
        default: begin
          write_reg(rccd_pkg::REG_WINDOW_LEFT, ($urandom_range(3) == 0) ?
                    rccd_pkg::CfgDataW'($urandom_range(4095)) :
                    rccd_pkg::CfgDataW'($urandom_range(319)));
          write_reg(rccd_pkg::REG_WINDOW_TOP, ($urandom_range(3) == 0) ?
                    rccd_pkg::CfgDataW'($urandom_range(4095)) :
                    rccd_pkg::CfgDataW'($urandom_range(239)));
          // mostly small limits so classes actually trigger
          for (int k = 0; k < rccd_pkg::NumClasses; k++)
            write_reg(rccd_pkg::CfgIndexW'(rccd_pkg::REG_RED_LIMIT + k),
                      ($urandom_range(3) == 0) ? rccd_pkg::CfgDataW'($urandom_range(4095)) :
                                                 rccd_pkg::CfgDataW'($urandom_range(40)));
        end
      endcase
      // a write past the end of the register list must change nothing
      write_reg(rccd_pkg::CfgIndexW'($urandom_range(15, NumRegs)),
                rccd_pkg::CfgDataW'($urandom_range(4095)));
      target = pixels_sent + 160;
      while (pixels_sent < target) begin
        len = $urandom_range(40, 1);
        for (int i = 0; i < len; i++) send_pixel(random_pixel(i == len - 1));
      end
    end
  endtask

  initial begin
    load_reset_state();
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_box_edges();
    test_window_edges();
    test_count_carry();
    test_random_frames();

    wait_idle();
    if (mismatches == 0) begin
      $display("roi_color_class_detector_top regression: pass");
    end else begin
      $display("roi_color_class_detector_top regression: fail");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #3000000;
    $display("roi_color_class_detector_top regression: fail");
    $finish;
  end

endmodule
